// File: rtl/gsm_septet_unpacker_hex_core_assert.svh
// Assertion macros shared by the septet unpacker RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef GSM_SEPTET_UNPACKER_HEX_CORE_ASSERT_SVH
`define GSM_SEPTET_UNPACKER_HEX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GSU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define GSU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define GSU_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GSU_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/gsu_pkg.sv
package gsu_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_req;
    } t_in_word;

    typedef struct packed {
        logic [6:0] septet;
        logic       last;
        logic       bad_char;
    } t_out_word;

    // What the front end makes of one character.
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_BAD   = 2'd1,
        CMD_OCTET = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic       start;
        t_cmd_kind  kind;
        logic [7:0] octet;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // Up to two result writes per command from the back end into the result queue.
    typedef struct packed {
        logic      en0;
        logic      en1;
        t_out_word d0;
        t_out_word d1;
    } t_res_wr;

    localparam logic [2:0] BITPOS_RESET = 3'd7;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: rtl/gsu_front.sv
module gsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  gsu_pkg::t_in_word i_in_word,
    output logic             o_cmd_valid,
    output gsu_pkg::t_cmd    o_cmd
);

    logic [3:0] r_high_nibble;
    logic [3:0] n_high_nibble;
    logic       r_nibble_pending;
    logic       n_nibble_pending;
    logic [4:0] dec;
    logic       pending_eff;

    always_comb begin
        dec              = gsu_pkg::hex_decode(i_in_word.char_code);
        // A start mark always makes this character the first digit of a pair.
        pending_eff      = r_nibble_pending && !i_in_word.start_req;
        n_high_nibble    = r_high_nibble;
        n_nibble_pending = pending_eff;
        o_cmd.start      = i_in_word.start_req;
        o_cmd.octet      = {r_high_nibble, dec[3:0]};
        if (!dec[4]) begin
            o_cmd.kind       = gsu_pkg::CMD_BAD;
            n_nibble_pending = 1'b0;
        end else if (!pending_eff) begin
            o_cmd.kind       = gsu_pkg::CMD_NONE;
            n_high_nibble    = dec[3:0];
            n_nibble_pending = 1'b1;
        end else begin
            o_cmd.kind       = gsu_pkg::CMD_OCTET;
            n_nibble_pending = 1'b0;
        end
        o_cmd_valid = i_accept && (i_in_word.start_req || (o_cmd.kind != gsu_pkg::CMD_NONE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble_pending <= 1'b0;
        end else if (i_accept) begin
            r_nibble_pending <= n_nibble_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_high_nibble <= n_high_nibble;
        end
    end

endmodule

// File: rtl/gsu_cmd_q.sv
module gsu_cmd_q #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gsu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output gsu_pkg::t_cmd o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsu_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_fire;
    logic             pop_fire;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_mem[r_rd_ptr];
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_fire) - CNT_W'(pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/gsu_back.sv
`include "gsm_septet_unpacker_hex_core_assert.svh"

module gsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  gsu_pkg::t_cmd    i_cmd,
    input  logic             i_room,
    output logic             o_cmd_pop,
    output gsu_pkg::t_res_wr o_wr
);

    gsu_pkg::t_phase r_phase;
    gsu_pkg::t_phase n_phase;
    logic [7:0]      r_left;
    logic [7:0]      n_left;
    logic [2:0]      r_bitpos;
    logic [2:0]      n_bitpos;
    logic [6:0]      r_carry;
    logic [6:0]      n_carry;

    gsu_pkg::t_phase e_phase;
    logic [7:0]      e_left;
    logic [2:0]      e_bitpos;
    logic [6:0]      e_carry;
    logic [2:0]      shift;
    logic [7:0]      shifted;
    logic [7:0]      high_part;
    logic [6:0]      sep0;
    logic [6:0]      carry_new;
    logic [7:0]      left1;
    logic [7:0]      left2;
    logic            wrap;
    logic            second;

    assign o_cmd_pop = i_cmd_valid && i_room;

    // State as seen after an optional start mark, and the unpacking arithmetic.
    always_comb begin
        e_phase   = i_cmd.start ? gsu_pkg::PH_LEN : r_phase;
        e_left    = i_cmd.start ? 8'd0 : r_left;
        e_bitpos  = i_cmd.start ? gsu_pkg::BITPOS_RESET : r_bitpos;
        e_carry   = i_cmd.start ? 7'd0 : r_carry;
        shift     = (e_bitpos == 3'd0) ? 3'd7 : e_bitpos;
        shifted   = i_cmd.octet << (3'd7 - shift);
        high_part = i_cmd.octet >> shift;
        sep0      = e_carry | shifted[6:0];
        carry_new = high_part[6:0];
        left1     = e_left - 8'd1;
        left2     = e_left - 8'd2;
        wrap      = (shift == 3'd1);
        second    = wrap && (left1 != 8'd0);
    end

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_bitpos = r_bitpos;
        n_carry  = r_carry;
        if (o_cmd_pop) begin
            n_phase  = e_phase;
            n_left   = e_left;
            n_bitpos = e_bitpos;
            n_carry  = e_carry;
            unique case (i_cmd.kind)
                gsu_pkg::CMD_BAD: begin
                    n_phase = gsu_pkg::PH_IDLE;
                end
                gsu_pkg::CMD_OCTET: begin
                    if (e_phase == gsu_pkg::PH_LEN) begin
                        n_left  = i_cmd.octet;
                        n_phase = (i_cmd.octet == 8'd0) ? gsu_pkg::PH_IDLE : gsu_pkg::PH_DATA;
                    end else if (e_phase == gsu_pkg::PH_DATA) begin
                        n_left   = second ? left2 : left1;
                        n_carry  = wrap ? 7'd0 : carry_new;
                        n_bitpos = wrap ? gsu_pkg::BITPOS_RESET : shift - 3'd1;
                        if ((left1 == 8'd0) || (second && (left2 == 8'd0))) begin
                            n_phase = gsu_pkg::PH_IDLE;
                        end
                    end
                end
                gsu_pkg::CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Result writes.
    always_comb begin
        o_wr = '0;
        if (o_cmd_pop) begin
            unique case (i_cmd.kind)
                gsu_pkg::CMD_BAD: begin
                    if (e_phase != gsu_pkg::PH_IDLE) begin
                        o_wr.en0         = 1'b1;
                        o_wr.d0.bad_char = 1'b1;
                    end
                end
                gsu_pkg::CMD_OCTET: begin
                    if (e_phase == gsu_pkg::PH_DATA) begin
                        o_wr.en0       = 1'b1;
                        o_wr.d0.septet = sep0;
                        o_wr.d0.last   = (left1 == 8'd0);
                        o_wr.en1       = second;
                        o_wr.d1.septet = carry_new;
                        o_wr.d1.last   = (left2 == 8'd0);
                    end
                end
                gsu_pkg::CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= gsu_pkg::PH_IDLE;
            r_left   <= 8'd0;
            r_bitpos <= gsu_pkg::BITPOS_RESET;
            r_carry  <= 7'd0;
        end else begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_bitpos <= n_bitpos;
            r_carry  <= n_carry;
        end
    end

    `GSU_ASSERT_IMP(a_second_needs_first, i_clk, i_rst_n, o_wr.en1, o_wr.en0)
    `GSU_ASSERT_IMP(a_no_septet_past_last, i_clk, i_rst_n, o_wr.en1, !o_wr.d0.last)
    `GSU_ASSERT_IMP(a_write_has_room, i_clk, i_rst_n, o_wr.en0, i_room)
    `GSU_ASSERT_NXT(a_idle_after_end, i_clk, i_rst_n, o_wr.en0 && (o_wr.d0.last || o_wr.d0.bad_char), r_phase == gsu_pkg::PH_IDLE)

endmodule

// File: rtl/gsu_res_q.sv
module gsu_res_q #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsu_pkg::t_res_wr  i_wr,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_empty,
    output gsu_pkg::t_out_word o_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsu_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop_fire;

    // Room means space for the two results one octet can produce.
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_empty  = (r_count == '0);
    assign o_word   = r_mem[r_rd_ptr];
    assign pop_fire = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_wr.en0) + PTR_W'(i_wr.en1);
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_wr.en0) + CNT_W'(i_wr.en1) - CNT_W'(pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en0) begin
            r_mem[r_wr_ptr] <= i_wr.d0;
        end
        if (i_wr.en1) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_wr.d1;
        end
    end

endmodule

// File: rtl/gsm_septet_unpacker_hex_core.sv
// Channel   Direction  Handshake     Word
// input     in         push / full   i_in_word  (char_code, start_req)
// result    out        pop / empty   o_out_word (septet, last, bad_char)
//
// One character is taken per clock while full is low; the front end never stalls on its own.
// A result passes through the command queue and then the result queue before it shows on the outputs.
// An octet needs two characters and yields at most two words, so with pop held high the
// result queue never backs up and full stays low, even on the octet with the eighth septet.
// When the reader stalls, the back end waits once the result queue holds more than two words,
// two commands collect and full rises until words are popped again.
// Reset is synchronous and active low and clears both queues and the message state at once.

module gsm_septet_unpacker_hex_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  gsu_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output gsu_pkg::t_out_word o_out_word
);

    logic             accept;
    logic             front_valid;
    gsu_pkg::t_cmd    front_cmd;
    logic             cmd_valid;
    gsu_pkg::t_cmd    cmd_head;
    logic             cmd_pop;
    logic             res_room;
    gsu_pkg::t_res_wr res_wr;

    // The character is taken whenever the command queue has a free slot, even if it
    // produces no command (first digit of a pair).
    assign accept = push && !full;

    // Front end: hex decoding and pairing of digits into octets.
    gsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_word   (i_in_word),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    // Short command queue that decouples the front end from the unpacker.
    gsu_cmd_q #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    // Back end: length capture, septet unpacking, count tracking and the idle rule.
    // It takes a command only when the result queue can absorb two words.
    gsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .i_room      (res_room),
        .o_cmd_pop   (cmd_pop),
        .o_wr        (res_wr)
    );

    // Result queue feeding the output port, oldest word first.
    gsu_res_q #(
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_pop   (pop),
        .o_room  (res_room),
        .o_empty (empty),
        .o_word  (o_out_word)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Testbench for the hex-fed GSM septet unpacker.
// Characters are pushed into the block from a queue that is filled up front.
// A cycle-free copy of the decoder predicts the septets and bad-character flags that each accepted
// character produces. Every word popped from the block is compared with the
// oldest prediction still waiting.
module tb;

    localparam int ITEM_TARGET    = 1950;
    localparam int MAX_ERR_PRINTS = 40;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    // Receiver behavior: steady draining, coin-flip pops, or long stall runs.
    typedef enum logic [1:0] {
        RX_STEADY = 2'd0,
        RX_COIN   = 2'd1,
        RX_BURSTY = 2'd2
    } t_rx_mode;

    // One pending character. A set hold bit keeps it back until every
    // predicted septet has been popped from the block.
    typedef struct packed {
        logic              hold;
        gsu_pkg::t_in_word word;
    } t_char_slot;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    gsu_pkg::t_in_word  i_in_word = '0;
    logic               empty;
    logic               pop       = 1'b0;
    gsu_pkg::t_out_word o_out_word;

    t_char_slot         char_slot_q[$];
    gsu_pkg::t_out_word septet_expect_q[$];
    int                 err_count = 0;

    // Sender burst and gap counters.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern.
    t_rx_mode rx_mode    = RX_STEADY;
    int       rx_mode_cnt = 0;
    int       stall_left  = 0;

    // Mirror of the decoder state, at its reset values.
    logic [3:0] hi_nib     = 4'd0;
    logic       nib_held   = 1'b0;
    logic       len_done   = 1'b0;
    logic       msg_active = 1'b0;
    logic [7:0] left_cnt   = 8'd0;
    logic [2:0] bit_pos    = 3'd7;
    logic [6:0] carry      = 7'd0;

    gsm_septet_unpacker_hex_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // Value of an ASCII hex digit, or -1 for any other character.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= ASCII_ZERO && c <= ASCII_ZERO + 8'd9) begin
            return int'(c - ASCII_ZERO);
        end
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_A + 8'd5) begin
            return int'(c - ASCII_UPPER_A) + 10;
        end
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_A + 8'd5) begin
            return int'(c - ASCII_LOWER_A) + 10;
        end
        return -1;
    endfunction

    // Hex digit for a nibble; letters come in either case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return ASCII_ZERO + 8'(n);
        end
        if ($urandom_range(1) == 0) begin
            return ASCII_UPPER_A + 8'(n - 4'd10);
        end
        return ASCII_LOWER_A + 8'(n - 4'd10);
    endfunction

    // Any character that is not a hex digit.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (hex_digit(c) >= 0);
        return c;
    endfunction

    function automatic int idle_gap();
        int p;
        p = $urandom_range(99);
        if (p < 30) begin
            return 0;
        end
        if (p < 90) begin
            return $urandom_range(4, 1);
        end
        return $urandom_range(30, 5);
    endfunction

    function automatic int pick_count();
        int p;
        p = $urandom_range(99);
        if (p < 4) begin
            return 0;
        end
        if (p < 80) begin
            return $urandom_range(16, 1);
        end
        if (p < 98) begin
            return $urandom_range(64, 17);
        end
        return $urandom_range(255, 65);
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic s, input logic h);
        t_char_slot slot;
        slot.hold           = h;
        slot.word.char_code = c;
        slot.word.start_req = s;
        char_slot_q.push_back(slot);
    endtask

    // A message written as text: the first character carries the start mark.
    task automatic queue_text(input string txt, input logic h);
        for (int i = 0; i < txt.len(); i++) begin
            queue_char(txt[i], i == 0, (i == 0) && h);
        end
    endtask

    // Records one delivered septet; the count running out ends the message.
    task automatic deliver_septet(input logic [6:0] sep);
        gsu_pkg::t_out_word r;
        left_cnt   = left_cnt - 8'd1;
        r.septet   = sep;
        r.last     = (left_cnt == 8'd0);
        r.bad_char = 1'b0;
        septet_expect_q.push_back(r);
        if (left_cnt == 8'd0) begin
            msg_active = 1'b0;
        end
    endtask

    // Advances the decoder mirror by one accepted character.
    task automatic decode_char(input gsu_pkg::t_in_word w);
        int                 digit;
        logic [7:0]         octet;
        logic [7:0]         shifted;
        logic [2:0]         shift;
        gsu_pkg::t_out_word r;
        if (w.start_req) begin
            nib_held   = 1'b0;
            len_done   = 1'b0;
            msg_active = 1'b1;
            left_cnt   = 8'd0;
            bit_pos    = 3'd7;
            carry      = 7'd0;
        end
        if (!msg_active) begin
            return;
        end
        digit = hex_digit(w.char_code);
        if (digit < 0) begin
            // A non-hex character is flagged and drops the message.
            r.septet   = 7'd0;
            r.last     = 1'b0;
            r.bad_char = 1'b1;
            septet_expect_q.push_back(r);
            msg_active = 1'b0;
            nib_held   = 1'b0;
            return;
        end
        if (!nib_held) begin
            hi_nib   = 4'(digit);
            nib_held = 1'b1;
            return;
        end
        nib_held = 1'b0;
        octet    = {hi_nib, 4'(digit)};
        if (!len_done) begin
            // The first pair is the septet count; a zero count ends at once.
            len_done = 1'b1;
            left_cnt = octet;
            if (octet == 8'd0) begin
                msg_active = 1'b0;
            end
            return;
        end
        shift = (bit_pos == 3'd0) ? 3'd7 : bit_pos;
        shifted = octet << (3'd7 - shift);
        deliver_septet(carry | shifted[6:0]);
        shifted = octet >> shift;
        carry   = shifted[6:0];
        shift   = shift - 3'd1;
        if (shift == 3'd0) begin
            // Seven octets in, the carry holds a whole eighth septet, unless
            // the count already ran out on the first one.
            shift = 3'd7;
            if (msg_active) begin
                deliver_septet(carry);
            end
            carry = 7'd0;
        end
        bit_pos = shift;
    endtask

    // Sender: presents the front of the queue in bursts, holds a word until
    // the block takes it, and feeds every taken word to the predictor.
    always @(posedge i_clk) begin : char_driver
        logic took;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            took = push && !full;
            if (took) begin
                decode_char(i_in_word);
                void'(char_slot_q.pop_front());
            end
            if (took || !push) begin
                if (char_slot_q.size() == 0) begin
                    push <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (char_slot_q[0].hold && septet_expect_q.size() != 0) begin
                    // Let the block drain completely before this word goes in.
                    push <= 1'b0;
                end else begin
                    push      <= 1'b1;
                    i_in_word <= char_slot_q[0].word;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40, 1);
                        gap_left   = idle_gap();
                    end
                end
            end
        end
    end

    // Receiver: checks each popped word against the oldest prediction and
    // then chooses the next pop from the current stall pattern.
    always @(posedge i_clk) begin : septet_monitor
        gsu_pkg::t_out_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (septet_expect_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_ERR_PRINTS) begin
                        $display("%0t: unexpected word: expected none, %s %h last %b bad_char %b",
                                 $realtime, "actual septet", o_out_word.septet,
                                 o_out_word.last, o_out_word.bad_char);
                    end
                end else begin
                    want = septet_expect_q.pop_front();
                    if (o_out_word.septet !== want.septet || o_out_word.last !== want.last ||
                        o_out_word.bad_char !== want.bad_char) begin
                        err_count++;
                        if (err_count <= MAX_ERR_PRINTS) begin
                            $display({"%0t: mismatch: expected septet %h last %b bad_char %b,",
                                      " actual septet %h last %b bad_char %b"},
                                     $realtime, want.septet, want.last, want.bad_char,
                                     o_out_word.septet, o_out_word.last,
                                     o_out_word.bad_char);
                        end
                    end
                end
            end
            rx_mode_cnt++;
            if (rx_mode_cnt == 200) begin
                rx_mode_cnt = 0;
                rx_mode     = t_rx_mode'($urandom_range(2));
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (rx_mode == RX_COIN) begin
                pop <= 1'($urandom_range(1));
            end else if (rx_mode == RX_BURSTY && $urandom_range(7) == 0) begin
                stall_left = $urandom_range(20, 1);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int         count;
        int         n_oct;
        int         cut;
        int         extra;
        int         bad_at;
        int         shape;
        int         body_chars;
        int         msg_idx;
        logic [7:0] oct;
        logic       hold;

        // Directed part.
        // Zero count, then a trailing digit that the idle block ignores.
        queue_text("007", 1'b0);
        // Full-scale octet as a one-septet message, then a character past the count.
        queue_text("01FFa", 1'b0);
        // Non-hex characters at both ends of the code range, the second one
        // also carrying the start mark.
        queue_text("0", 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b0);
        // A restart in the middle of the length pair; this one waits for a
        // fully drained block first.
        queue_text("0", 1'b0);
        queue_text("0199", 1'b1);
        // Count of seven over seven octets: the eighth septet is never delivered.
        queue_text("07a0b1c2d3e4f5e6", 1'b0);

        // Random messages, mostly well formed, some cut short, some broken by
        // a bad character, some followed by characters that are ignored.
        body_chars = 0;
        msg_idx    = 0;
        while (body_chars < ITEM_TARGET) begin
            count  = pick_count();
            n_oct  = (count * 7 + 7) / 8;
            shape  = $urandom_range(99);
            hold   = (msg_idx == 0) || ($urandom_range(39) == 0);
            cut    = n_oct;
            extra  = 0;
            bad_at = -1;
            if (shape >= 75 && shape < 85) begin
                extra = $urandom_range(3, 1);
            end else if (shape >= 85 && shape < 93) begin
                cut = (n_oct == 0) ? 0 : $urandom_range(n_oct - 1);
            end else if (shape >= 93) begin
                bad_at = $urandom_range(2 * n_oct);
            end
            oct = 8'(count);
            queue_char(hex_char(oct[7:4]), 1'b1, hold);
            queue_char(hex_char(oct[3:0]), 1'b0, 1'b0);
            body_chars += 2;
            for (int k = 0; k <= 2 * cut; k++) begin
                if (k % 2 == 0) begin
                    oct = 8'($urandom_range(255));
                end
                if (k == bad_at) begin
                    queue_char(junk_char(), 1'b0, 1'b0);
                    body_chars++;
                    break;
                end
                if (k < 2 * cut) begin
                    queue_char(hex_char((k % 2 == 0) ? oct[7:4] : oct[3:0]), 1'b0, 1'b0);
                    body_chars++;
                end
            end
            // A cut message sometimes ends on a lone first digit.
            if (cut < n_oct && $urandom_range(1) == 1) begin
                queue_char(hex_char(4'($urandom_range(15))), 1'b0, 1'b0);
                body_chars++;
            end
            for (int k = 0; k < 2 * extra; k++) begin
                queue_char(hex_char(4'($urandom_range(15))), 1'b0, 1'b0);
            end
            // Now and then a few arbitrary characters without a start mark.
            if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    queue_char(8'($urandom_range(255)), 1'b0, 1'b0);
                end
            end
            msg_idx++;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_slot_q.size() != 0) begin
            @(posedge i_clk);
        end
        while (septet_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        // Keep running so that any stray word left after the last character still shows.
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
